>>> rtl/clb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clb_pkg
// Shared types and constants of the command list buffer.
// ----------------------------------------------------------------------------
package clb_pkg;

  localparam int unsigned ListDepth = 4096;
  localparam int unsigned OpW       = 3;
  localparam int unsigned IdxW      = 16;
  localparam int unsigned CodeW     = 16;
  localparam int unsigned ArgW      = 32;
  localparam int unsigned ErrW      = 3;
  localparam int unsigned StatW     = 2;
  localparam int unsigned CfgAddrW  = 3;
  localparam int unsigned CfgDataW  = 32;

  typedef enum logic [OpW-1:0] {
    OpClear      = 3'd0,
    OpStartWrite = 3'd1,
    OpStartRead  = 3'd2,
    OpPush       = 3'd3,
    OpPop        = 3'd4
  } op_e;

  typedef enum logic [ErrW-1:0] {
    ErrOk         = 3'd0,
    ErrRunning    = 3'd1,
    ErrWriteIndex = 3'd2,
    ErrNotReady   = 3'd3,
    ErrReadIndex  = 3'd4,
    ErrNotLoading = 3'd5,
    ErrOverflow   = 3'd6,
    ErrNotRunning = 3'd7
  } err_e;

  typedef enum logic [StatW-1:0] {
    PhEmpty   = 2'd0,
    PhLoading = 2'd1,
    PhReady   = 2'd2,
    PhRunning = 2'd3
  } phase_e;

  typedef enum logic [0:0] {
    RegEndOfList = 1'b0
  } reg_e;

  typedef struct packed {
    logic [CodeW-1:0] code;
    logic [ArgW-1:0]  arg_a;
    logic [ArgW-1:0]  arg_b;
    logic [ArgW-1:0]  arg_c;
  } entry_t;

  typedef struct packed {
    err_e   err;
    phase_e status;
    logic   rd;
    logic   hit;
  } stage_t;

endpackage

>>> rtl/clb_cmd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clb_cmd_if
// Command channel of the command list buffer.
// ----------------------------------------------------------------------------
interface clb_cmd_if;
  logic                       valid;
  logic                       ready;
  logic [clb_pkg::OpW-1:0]    op;
  logic [clb_pkg::IdxW-1:0]   start_index;
  logic [clb_pkg::CodeW-1:0]  cmd_code;
  logic [clb_pkg::ArgW-1:0]   cmd_arg_a;
  logic [clb_pkg::ArgW-1:0]   cmd_arg_b;
  logic [clb_pkg::ArgW-1:0]   cmd_arg_c;

  modport source (
    output valid, op, start_index, cmd_code, cmd_arg_a, cmd_arg_b, cmd_arg_c,
    input  ready
  );
  modport sink (
    input  valid, op, start_index, cmd_code, cmd_arg_a, cmd_arg_b, cmd_arg_c,
    output ready
  );
endinterface

>>> rtl/clb_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clb_res_if
// Result channel of the command list buffer.
// ----------------------------------------------------------------------------
interface clb_res_if;
  logic                       valid;
  logic                       ready;
  logic [clb_pkg::ErrW-1:0]   error_code;
  logic [clb_pkg::StatW-1:0]  list_status;
  logic [clb_pkg::CodeW-1:0]  out_code;
  logic [clb_pkg::ArgW-1:0]   out_arg_a;
  logic [clb_pkg::ArgW-1:0]   out_arg_b;
  logic [clb_pkg::ArgW-1:0]   out_arg_c;

  modport source (
    output valid, error_code, list_status, out_code, out_arg_a, out_arg_b, out_arg_c,
    input  ready
  );
  modport sink (
    input  valid, error_code, list_status, out_code, out_arg_a, out_arg_b, out_arg_c,
    output ready
  );
endinterface

>>> rtl/command_list_buffer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// command_list_buffer_core
// Command list store with empty, loading, ready and running phases, held in
// one synchronous memory, with a result word for every command word.
// ----------------------------------------------------------------------------
// Channel   Direction  Carries
// cmd_i     in         op, start_index, cmd_code, cmd_arg_a/b/c
// res_o     out        error_code, list_status, out_code, out_arg_a/b/c
// APB       in/out     end_of_list_code at byte address 0
//
// One command word can follow another every cycle while the result port does not
// stall. Its result is registered in the stage register, with the memory read of
// a pop, when the word is accepted, and moves on into the output register.
// A stalled result port holds both stages and then drops cmd_i.ready. No
// clearing pass follows reset: entries below the start of the current load
// read as zero.
// ----------------------------------------------------------------------------
module command_list_buffer_core #(
  parameter int unsigned LIST_DEPTH = clb_pkg::ListDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  clb_cmd_if.sink                       cmd_i,
  clb_res_if.source                     res_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [clb_pkg::CfgAddrW-1:0]  paddr,
  input  logic [clb_pkg::CfgDataW-1:0]  pwdata,
  output logic [clb_pkg::CfgDataW-1:0]  prdata,
  output logic                          pready
);

  localparam int unsigned AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int unsigned PW = $clog2(LIST_DEPTH + 1);
  localparam logic [PW-1:0] DepthP = PW'(LIST_DEPTH);
  localparam logic [clb_pkg::IdxW:0] DepthI = (clb_pkg::IdxW + 1)'(LIST_DEPTH);

  clb_pkg::entry_t mem_q [LIST_DEPTH];
  clb_pkg::entry_t rdata_q;

  logic [clb_pkg::CodeW-1:0] eol_q;
  logic                      cfg_we;

  clb_pkg::phase_e phase_q, phase_d;
  logic [PW-1:0]   wp_q, wp_d;
  logic [PW-1:0]   rp_q, rp_d;
  logic [PW-1:0]   base_q, base_d;

  clb_pkg::stage_t s1_q, s1_d;
  logic            s1_v_q;
  logic            out_v_q;
  clb_pkg::entry_t out_data_q, out_data_d;
  clb_pkg::err_e   out_err_q;
  clb_pkg::phase_e out_stat_q;

  logic            acc;
  logic            out_free;
  logic            s1_move;
  logic            we;
  logic            re;
  logic            idx_big;
  clb_pkg::err_e   err;
  logic            hit;
  clb_pkg::entry_t wdata;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready
                  && (paddr[clb_pkg::CfgAddrW-1:2] == clb_pkg::RegEndOfList);
  assign prdata = (paddr[clb_pkg::CfgAddrW-1:2] == clb_pkg::RegEndOfList)
                  ? {{(clb_pkg::CfgDataW - clb_pkg::CodeW){1'b0}}, eol_q}
                  : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eol_q <= '0;
    end else if (cfg_we) begin
      eol_q <= pwdata[clb_pkg::CodeW-1:0];
    end
  end

  assign out_free = !out_v_q || res_o.ready;
  assign s1_move  = s1_v_q && out_free;
  assign cmd_i.ready = !s1_v_q || out_free;
  assign acc = cmd_i.valid && cmd_i.ready;
  assign idx_big = {1'b0, cmd_i.start_index} >= DepthI;

  // Next phase, pointers and error code of the accepted command word.
  always_comb begin
    phase_d = phase_q;
    wp_d    = wp_q;
    rp_d    = rp_q;
    base_d  = base_q;
    err     = clb_pkg::ErrOk;
    we      = 1'b0;
    re      = 1'b0;
    hit     = 1'b0;
    if (acc) begin
      case (clb_pkg::op_e'(cmd_i.op))
        clb_pkg::OpClear: begin
          phase_d = clb_pkg::PhEmpty;
          wp_d    = '0;
          rp_d    = '0;
          base_d  = '0;
        end
        clb_pkg::OpStartWrite: begin
          if (phase_q == clb_pkg::PhRunning) begin
            err = clb_pkg::ErrRunning;
          end else if (idx_big) begin
            err = clb_pkg::ErrWriteIndex;
          end else begin
            phase_d = clb_pkg::PhLoading;
            wp_d    = PW'(cmd_i.start_index);
            rp_d    = '0;
            base_d  = PW'(cmd_i.start_index);
          end
        end
        clb_pkg::OpStartRead: begin
          if (phase_q != clb_pkg::PhReady) begin
            err = clb_pkg::ErrNotReady;
          end else if (idx_big) begin
            err = clb_pkg::ErrReadIndex;
          end else begin
            phase_d = clb_pkg::PhRunning;
            rp_d    = PW'(cmd_i.start_index);
          end
        end
        clb_pkg::OpPush: begin
          if (phase_q != clb_pkg::PhLoading) begin
            err = clb_pkg::ErrNotLoading;
          end else if (wp_q >= DepthP) begin
            err = clb_pkg::ErrOverflow;
          end else begin
            we   = 1'b1;
            wp_d = PW'(wp_q + PW'(1));
            if (cmd_i.cmd_code == eol_q) begin
              phase_d = clb_pkg::PhReady;
            end
          end
        end
        clb_pkg::OpPop: begin
          if (phase_q != clb_pkg::PhRunning) begin
            err = clb_pkg::ErrNotRunning;
          end else if (rp_q >= wp_q || rp_q >= DepthP) begin
            err     = clb_pkg::ErrReadIndex;
            phase_d = clb_pkg::PhEmpty;
            wp_d    = '0;
            rp_d    = '0;
            base_d  = '0;
          end else begin
            re   = 1'b1;
            hit  = rp_q >= base_q;
            rp_d = PW'(rp_q + PW'(1));
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Stage and output word contents.
  always_comb begin
    s1_d.err    = err;
    s1_d.status = phase_d;
    s1_d.rd     = re;
    s1_d.hit    = hit;
    out_data_d  = (s1_q.rd && s1_q.hit) ? rdata_q : '0;
  end

  assign wdata.code  = cmd_i.cmd_code;
  assign wdata.arg_a = cmd_i.cmd_arg_a;
  assign wdata.arg_b = cmd_i.cmd_arg_b;
  assign wdata.arg_c = cmd_i.cmd_arg_c;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wp_q[AW-1:0]] <= wdata;
    end
    if (re) begin
      rdata_q <= mem_q[rp_q[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= clb_pkg::PhEmpty;
      wp_q    <= '0;
      rp_q    <= '0;
      base_q  <= '0;
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      wp_q    <= wp_d;
      rp_q    <= rp_d;
      base_q  <= base_d;
      if (acc) begin
        s1_v_q <= 1'b1;
      end else if (s1_move) begin
        s1_v_q <= 1'b0;
      end
      if (s1_move) begin
        out_v_q <= 1'b1;
      end else if (res_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_q <= s1_d;
    end
    if (s1_move) begin
      out_data_q <= out_data_d;
      out_err_q  <= s1_q.err;
      out_stat_q <= s1_q.status;
    end
  end

  assign res_o.valid       = out_v_q;
  assign res_o.error_code  = out_err_q;
  assign res_o.list_status = out_stat_q;
  assign res_o.out_code    = out_data_q.code;
  assign res_o.out_arg_a   = out_data_q.arg_a;
  assign res_o.out_arg_b   = out_data_q.arg_b;
  assign res_o.out_arg_c   = out_data_q.arg_c;

  a_empty_ptrs : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == clb_pkg::PhEmpty) |-> (wp_q == '0 && rp_q == '0))
    else $error("empty phase with non-zero pointers");

  a_rp_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rp_q <= DepthP)
    else $error("read pointer beyond list depth");

  a_load_base : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == clb_pkg::PhLoading) |-> (base_q <= wp_q))
    else $error("write pointer below load start");

  a_stage_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && !out_free) |=> s1_v_q)
    else $error("stage word lost under stall");

  a_pop_stage : assert property (@(posedge clk_i) disable iff (!rst_ni)
    re |=> (s1_v_q && s1_q.rd))
    else $error("pop read not tracked in stage");

endmodule

>>> test/clb_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clb_result_checker
// Watches the command, result and register ports of the command list buffer.
// It keeps its own copy of the list store, works out the result word that
// every accepted command word must produce, and compares each accepted result
// word field by field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module clb_result_checker
  import clb_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  clb_cmd_if                   cmd_i,
  clb_res_if                   res_i,
  input  logic                 psel_i,
  input  logic                 penable_i,
  input  logic                 pwrite_i,
  input  logic                 pready_i,
  input  logic [CfgAddrW-1:0]  paddr_i,
  input  logic [CfgDataW-1:0]  pwdata_i,
  output int unsigned          mismatches_o,
  output int unsigned          pending_o
);

  localparam int unsigned PtrW = $clog2(ListDepth) + 1;
  localparam logic [CfgAddrW-1:0] EolAddr = CfgAddrW'(4 * int'(RegEndOfList));

  typedef struct packed {
    err_e   err;
    phase_e status;
    entry_t popped;
  } outcome_t;

  entry_t           entries     [ListDepth];
  bit               entry_valid [ListDepth];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  phase_e           list_phase;
  logic [CodeW-1:0] eol_code;
  outcome_t         expected_outcomes [$];

  function automatic void wipe_list();
    entry_valid = '{default: 1'b0};
    wr_ptr      = '0;
    rd_ptr      = '0;
    list_phase  = PhEmpty;
  endfunction

  function automatic outcome_t apply_command(logic [OpW-1:0] op, logic [IdxW-1:0] idx,
                                             entry_t word);
    outcome_t res;
    res     = '0;
    res.err = ErrOk;
    case (op)
      OpClear: begin
        wipe_list();
      end
      OpStartWrite: begin
        if (list_phase == PhRunning) begin
          res.err = ErrRunning;
        end else if (idx >= ListDepth) begin
          res.err = ErrWriteIndex;
        end else begin
          wipe_list();
          wr_ptr     = PtrW'(idx);
          list_phase = PhLoading;
        end
      end
      OpStartRead: begin
        if (list_phase != PhReady) begin
          res.err = ErrNotReady;
        end else if (idx >= ListDepth) begin
          res.err = ErrReadIndex;
        end else begin
          rd_ptr     = PtrW'(idx);
          list_phase = PhRunning;
        end
      end
      OpPush: begin
        if (list_phase != PhLoading) begin
          res.err = ErrNotLoading;
        end else if (wr_ptr >= ListDepth) begin
          res.err = ErrOverflow;
        end else begin
          entries[wr_ptr]     = word;
          entry_valid[wr_ptr] = 1'b1;
          wr_ptr              = wr_ptr + 1'b1;
          if (word.code == eol_code) begin
            list_phase = PhReady;
          end
        end
      end
      OpPop: begin
        if (list_phase != PhRunning) begin
          res.err = ErrNotRunning;
        end else if (rd_ptr >= wr_ptr || rd_ptr >= ListDepth) begin
          wipe_list();
          res.err = ErrReadIndex;
        end else begin
          if (entry_valid[rd_ptr]) begin
            res.popped = entries[rd_ptr];
          end
          rd_ptr = rd_ptr + 1'b1;
        end
      end
      default: begin
      end
    endcase
    res.status = list_phase;
    return res;
  endfunction

  function automatic void check_field(string name, logic [ArgW-1:0] want,
                                      logic [ArgW-1:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches_o++;
    end
  endfunction

  always @(posedge clk_i) begin : watch
    outcome_t want;
    entry_t   word;
    if (!rst_ni) begin
      wipe_list();
      eol_code = '0;
      expected_outcomes.delete();
      mismatches_o = 0;
      pending_o    = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == EolAddr) begin
        eol_code = pwdata_i[CodeW-1:0];
      end
      if (cmd_i.valid && cmd_i.ready) begin
        word.code  = cmd_i.cmd_code;
        word.arg_a = cmd_i.cmd_arg_a;
        word.arg_b = cmd_i.cmd_arg_b;
        word.arg_c = cmd_i.cmd_arg_c;
        expected_outcomes.push_back(apply_command(cmd_i.op, cmd_i.start_index, word));
      end
      if (res_i.valid && res_i.ready) begin
        if (expected_outcomes.size() == 0) begin
          $error("result word accepted with no prediction outstanding");
          mismatches_o++;
        end else begin
          want = expected_outcomes.pop_front();
          check_field("error_code", ArgW'(want.err), ArgW'(res_i.error_code));
          check_field("list_status", ArgW'(want.status), ArgW'(res_i.list_status));
          check_field("out_code", ArgW'(want.popped.code), ArgW'(res_i.out_code));
          check_field("out_arg_a", want.popped.arg_a, res_i.out_arg_a);
          check_field("out_arg_b", want.popped.arg_b, res_i.out_arg_b);
          check_field("out_arg_c", want.popped.arg_c, res_i.out_arg_c);
        end
      end
      pending_o = expected_outcomes.size();
    end
  end

endmodule

>>> test/tb_command_list_buffer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_command_list_buffer_core
// Drives the command list buffer with a directed run over its error cases and
// then with randomised load-and-replay sessions mixed with stray commands,
// under three end-of-list codes and three patterns of port back-pressure.
// ----------------------------------------------------------------------------
module tb_command_list_buffer_core;
  import clb_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned PtrW = $clog2(ListDepth) + 1;
  localparam logic [CfgAddrW-1:0] EolAddr = CfgAddrW'(4 * int'(RegEndOfList));
  localparam logic [OpW-1:0] OpUnusedLow  = 3'd5;
  localparam logic [OpW-1:0] OpUnusedHigh = 3'd7;

  logic                clk;
  logic                rst_n;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [CfgAddrW-1:0] paddr;
  logic [CfgDataW-1:0] pwdata;
  logic [CfgDataW-1:0] prdata;
  logic                pready;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned cycle_count;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned stall_left;
  int unsigned items_sent;
  bit          pressure_req;

  // Shadow of the list position, used only to steer the stimulus.
  phase_e           plan_phase;
  logic [PtrW-1:0]  plan_wr;
  logic [PtrW-1:0]  plan_rd;
  logic [CodeW-1:0] plan_eol;

  clb_cmd_if cmd_ch ();
  clb_res_if res_ch ();

  command_list_buffer_core dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .cmd_i   (cmd_ch),
    .res_o   (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  clb_result_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cmd_i        (cmd_ch),
    .res_i        (res_ch),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("tb_command_list_buffer_core: errors");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
      res_ch.ready <= 1'b0;
    end else if (pressure_req) begin
      pressure_req = 1'b0;
      stall_left   = 300;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  function automatic void forget_list();
    plan_wr    = '0;
    plan_rd    = '0;
    plan_phase = PhEmpty;
  endfunction

  task automatic issue(input logic [OpW-1:0] op, input logic [IdxW-1:0] idx,
                       input logic [CodeW-1:0] code, input logic [ArgW-1:0] arg_a,
                       input logic [ArgW-1:0] arg_b, input logic [ArgW-1:0] arg_c);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(negedge clk);
    end
    cmd_ch.valid       <= 1'b1;
    cmd_ch.op          <= op;
    cmd_ch.start_index <= idx;
    cmd_ch.cmd_code    <= code;
    cmd_ch.cmd_arg_a   <= arg_a;
    cmd_ch.cmd_arg_b   <= arg_b;
    cmd_ch.cmd_arg_c   <= arg_c;
    do @(posedge clk); while (!cmd_ch.ready);
    @(negedge clk);
    case (op)
      OpClear: begin
        forget_list();
      end
      OpStartWrite: begin
        if (plan_phase != PhRunning && idx < ListDepth) begin
          forget_list();
          plan_wr    = PtrW'(idx);
          plan_phase = PhLoading;
        end
      end
      OpStartRead: begin
        if (plan_phase == PhReady && idx < ListDepth) begin
          plan_rd    = PtrW'(idx);
          plan_phase = PhRunning;
        end
      end
      OpPush: begin
        if (plan_phase == PhLoading && plan_wr < ListDepth) begin
          plan_wr = plan_wr + 1'b1;
          if (code == plan_eol) begin
            plan_phase = PhReady;
          end
        end
      end
      OpPop: begin
        if (plan_phase == PhRunning) begin
          if (plan_rd >= plan_wr) begin
            forget_list();
          end else begin
            plan_rd = plan_rd + 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    if (op <= OpPop) begin
      items_sent++;
    end
  endtask

  task automatic write_eol(input logic [CodeW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= EolAddr;
    pwdata  <= CfgDataW'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    plan_eol = value;
  endtask

  task automatic settle();
    cmd_ch.valid <= 1'b0;
    while (pending != 0) begin
      @(negedge clk);
    end
    repeat (4) @(negedge clk);
  endtask

  task automatic directed_checks();
    issue(OpPop, '0, '0, '0, '0, '0);
    issue(OpPush, '0, 16'h1234, '0, '0, '0);
    issue(OpStartRead, '0, '0, '0, '0, '0);
    issue(OpUnusedLow, '1, '1, '1, '1, '1);
    issue(OpUnusedHigh, '0, '0, '0, '0, '0);
    issue(OpStartWrite, IdxW'(ListDepth), '0, '0, '0, '0);
    issue(OpStartWrite, '0, '0, '0, '0, '0);
    issue(OpPush, '0, '1, '1, '1, '1);
    issue(OpPush, '0, plan_eol, '0, '0, '0);
    issue(OpPush, '0, 16'h0001, '0, '0, '0);
    issue(OpStartRead, IdxW'(ListDepth), '0, '0, '0, '0);
    issue(OpStartRead, '0, '0, '0, '0, '0);
    issue(OpStartWrite, '0, '0, '0, '0, '0);
    repeat (3) issue(OpPop, '0, '0, '0, '0, '0);
    // Entry zero keeps old contents but was dropped by the new load.
    issue(OpStartWrite, 16'd1, '0, '0, '0, '0);
    issue(OpPush, '0, plan_eol, 32'hDEAD_BEEF, 32'h0123_4567, 32'h89AB_CDEF);
    issue(OpStartRead, '0, '0, '0, '0, '0);
    repeat (3) issue(OpPop, '0, '0, '0, '0, '0);
    issue(OpStartWrite, IdxW'(ListDepth - 1), '0, '0, '0, '0);
    issue(OpPush, '0, ~plan_eol, '1, '0, '1);
    issue(OpPush, '0, plan_eol, '0, '1, '0);
    issue(OpClear, '0, '0, '0, '0, '0);
  endtask

  task automatic replay_list();
    int unsigned pushes;
    int unsigned pops;
    int unsigned roll;
    int unsigned k;
    logic [IdxW-1:0]  idx;
    logic [CodeW-1:0] code;
    if ($urandom_range(0, 9) == 0) begin
      issue(OpClear, 16'($urandom), 16'($urandom), $urandom, $urandom, $urandom);
    end
    roll = $urandom_range(0, 99);
    if (roll < 70) begin
      idx = 16'($urandom_range(0, 63));
    end else if (roll < 85) begin
      idx = 16'($urandom_range(ListDepth - 8, ListDepth - 1));
    end else if (roll < 95) begin
      idx = 16'($urandom_range(0, ListDepth - 1));
    end else begin
      idx = 16'($urandom_range(ListDepth, 65535));
    end
    issue(OpStartWrite, idx, 16'($urandom), $urandom, $urandom, $urandom);
    pushes = $urandom_range(1, 6);
    for (k = 0; k < pushes; k++) begin
      code = 16'($urandom);
      if (k == pushes - 1 && $urandom_range(0, 99) < 85) begin
        code = plan_eol;
      end
      issue(OpPush, 16'($urandom), code, $urandom, $urandom, $urandom);
    end
    roll = $urandom_range(0, 99);
    if (roll < 75) begin
      idx = (plan_wr > 8) ? 16'($urandom_range(plan_wr - 8, plan_wr))
                          : 16'($urandom_range(0, plan_wr));
    end else if (roll < 90 && plan_wr < ListDepth) begin
      idx = 16'($urandom_range(plan_wr, ListDepth - 1));
    end else begin
      idx = 16'($urandom_range(ListDepth, 65535));
    end
    issue(OpStartRead, idx, 16'($urandom), $urandom, $urandom, $urandom);
    pops = (plan_phase == PhRunning && plan_wr > plan_rd) ? plan_wr - plan_rd + 1 : 1;
    roll = $urandom_range(0, 99);
    if (roll < 15) begin
      pops = $urandom_range(0, pops);
    end else if (roll < 25) begin
      pops++;
    end
    repeat (pops) issue(OpPop, 16'($urandom), 16'($urandom), $urandom, $urandom, $urandom);
  endtask

  task automatic random_phase(input int unsigned count);
    int unsigned goal;
    goal = items_sent + count;
    while (items_sent < goal) begin
      if ($urandom_range(0, 99) < 15) begin
        issue(3'($urandom_range(0, 7)),
              ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 63)),
              16'($urandom), $urandom, $urandom, $urandom);
      end else begin
        replay_list();
      end
    end
  endtask

  initial begin
    rst_n              = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    cmd_ch.valid       = 1'b0;
    cmd_ch.op          = '0;
    cmd_ch.start_index = '0;
    cmd_ch.cmd_code    = '0;
    cmd_ch.cmd_arg_a   = '0;
    cmd_ch.cmd_arg_b   = '0;
    cmd_ch.cmd_arg_c   = '0;
    res_ch.ready       = 1'b0;
    send_idle_pct      = 0;
    recv_idle_pct      = 0;
    stall_left         = 0;
    pressure_req       = 1'b0;
    items_sent         = 0;
    plan_eol           = '0;
    forget_list();
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    write_eol(16'h00A5);
    directed_checks();
    settle();

    write_eol(16'h0000);
    send_idle_pct = 17;
    recv_idle_pct = 84;
    random_phase(550);
    settle();

    write_eol(16'hFFFF);
    send_idle_pct = 84;
    recv_idle_pct = 17;
    random_phase(550);
    settle();

    write_eol(16'($urandom));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    pressure_req  = 1'b1;
    random_phase(550);
    settle();

    if (mismatches == 0 && pending == 0) begin
      $display("tb_command_list_buffer_core: clean");
    end else begin
      $display("tb_command_list_buffer_core: errors");
    end
    $finish;
  end

endmodule
